FILE: design/egc_pkg.sv
// shared types and constants for the eulerian graph check block
`timescale 1ns / 1ps

package egc_pkg;

  // fixed widths of the request and result fields
  localparam int NODE_W    = 6;
  localparam int NODE_SPAN = 2 ** NODE_W;
  localparam int COUNT_W   = 7;

  // request modes
  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_DECLARE = 2'd1,
    MODE_EDGE    = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_LOAD,
    ST_SCAN,
    ST_ROWRD,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic mark_node;
    logic edge_start;
    logic edge_wr;
    logic walk_start;
    logic rd_from_stack;
    logic load_fresh;
    logic push;
    logic pop;
    logic out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fresh_empty;
    logic stack_empty;
  } dp_stat_t;

endpackage

FILE: design/egc_in_if.sv
// request channel interface: valid/ready with mode, node and target
`timescale 1ns / 1ps

interface egc_in_if;
  import egc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] target;

  modport source (output valid, output mode, output node, output target, input ready);
  modport sink   (input valid, input mode, input node, input target, output ready);
endinterface

FILE: design/egc_out_if.sv
// result channel interface: valid/ready with verdict, flag and counts
`timescale 1ns / 1ps

interface egc_out_if;
  import egc_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_eulerian;
  logic               all_even;
  logic [COUNT_W-1:0] reached_count;
  logic [COUNT_W-1:0] present_count;

  modport source (output valid, output is_eulerian, output all_even,
                  output reached_count, output present_count, input ready);
  modport sink   (input valid, input is_eulerian, input all_even,
                  input reached_count, input present_count, output ready);
endinterface

FILE: design/egc_ctrl.sv
// controller state machine: request decode, walk sequencing, result handoff
`timescale 1ns / 1ps

module egc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output egc_pkg::dp_cmd_t   cmd,
  input  egc_pkg::dp_stat_t  stat
);
  import egc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign out_valid = out_valid_r;
  assign in_fire   = in_valid && in_ready;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mode_t'(in_mode))
            MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            MODE_DECLARE: begin
              cmd.mark_node = 1'b1;
            end
            MODE_EDGE: begin
              cmd.mark_node  = 1'b1;
              cmd.edge_start = 1'b1;
              state_nxt      = ST_EDGE_WR;
            end
            MODE_QUERY: begin
              cmd.mark_node  = 1'b1;
              cmd.walk_start = 1'b1;
              state_nxt      = ST_LOAD;
            end
          endcase
        end
      end
      ST_EDGE_WR: begin
        cmd.edge_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_LOAD: begin
        cmd.load_fresh = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (!stat.fresh_empty) begin
          cmd.push = 1'b1;
        end else if (stat.stack_empty) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_ROWRD;
        end
      end
      ST_ROWRD: begin
        cmd.rd_from_stack = 1'b1;
        state_nxt         = ST_LOAD;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // the row write cycle only follows an accepted edge request
  a_edge_wr_follows_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EDGE_WR) |-> $past(in_fire && (in_mode == MODE_EDGE)))
    else $error("row write without an edge request");

  // a result only appears out of the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

endmodule

FILE: design/egc_dp.sv
// datapath: adjacency memory, node sets, walk stack, counters and result register
`timescale 1ns / 1ps

module egc_dp #(
  parameter int NODES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  egc_pkg::dp_cmd_t            cmd,
  output egc_pkg::dp_stat_t           stat,
  input  logic [egc_pkg::NODE_W-1:0]  in_node,
  input  logic [egc_pkg::NODE_W-1:0]  in_target,
  output logic                        out_is_eulerian,
  output logic                        out_all_even,
  output logic [egc_pkg::COUNT_W-1:0] out_reached_count,
  output logic [egc_pkg::COUNT_W-1:0] out_present_count
);
  import egc_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  // storage
  logic [NODES-1:0] adj_mem   [NODES];
  logic [IDX_W-1:0] stack_mem [NODES];

  logic [NODES-1:0] present_r, present_nxt;
  logic [NODES-1:0] parity_r, parity_nxt;
  logic [NODES-1:0] row_valid_r, row_valid_nxt;
  logic [CNT_W-1:0] present_cnt_r, present_cnt_nxt;

  logic [NODES-1:0] adj_q_r;
  logic             adj_v_r;
  logic [NODES-1:0] visited_r;
  logic [NODES-1:0] fresh_r;
  logic [CNT_W-1:0] reached_r;
  logic [IDX_W-1:0] sp_r;
  logic [IDX_W-1:0] stk_q_r;
  logic [IDX_W-1:0] src_r;
  logic [IDX_W-1:0] dst_r;

  logic               is_eulerian_r;
  logic               all_even_r;
  logic [COUNT_W-1:0] reached_out_r;
  logic [COUNT_W-1:0] present_out_r;

  logic [IDX_W-1:0] node_map [NODE_SPAN];
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] b_idx;
  logic [NODES-1:0] a_hot;
  logic [NODES-1:0] b_hot;
  logic [IDX_W-1:0] adj_addr;
  logic [NODES-1:0] row_cur;
  logic [NODES-1:0] low;
  logic [IDX_W-1:0] low_idx;
  logic             new_a;
  logic             new_b;
  logic             all_even;

  // node numbers wrap modulo the node count
  for (genvar g = 0; g < NODE_SPAN; g++) begin : g_map
    localparam int MAPPED = g % NODES;
    assign node_map[g] = IDX_W'(MAPPED);
  end

  assign a_idx    = node_map[in_node];
  assign b_idx    = node_map[in_target];
  assign a_hot    = NODES'(1) << a_idx;
  assign b_hot    = NODES'(1) << b_idx;
  assign adj_addr = cmd.rd_from_stack ? stk_q_r : a_idx;
  assign row_cur  = adj_v_r ? adj_q_r : '0;

  // lowest unvisited successor and its index
  assign low = fresh_r & (~fresh_r + NODES'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NODES; i++) begin
      if (low[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  // graph set updates
  assign new_a = cmd.mark_node & ~present_r[a_idx];
  assign new_b = cmd.edge_start & ~present_r[b_idx] & (b_idx != a_idx);

  always_comb begin
    present_nxt     = present_r;
    parity_nxt      = parity_r;
    row_valid_nxt   = row_valid_r;
    present_cnt_nxt = present_cnt_r + CNT_W'(new_a) + CNT_W'(new_b);
    if (cmd.clear) begin
      present_nxt     = '0;
      parity_nxt      = '0;
      row_valid_nxt   = '0;
      present_cnt_nxt = '0;
    end else begin
      if (cmd.mark_node) begin
        present_nxt = present_nxt | a_hot;
      end
      if (cmd.edge_start) begin
        present_nxt = present_nxt | b_hot;
        parity_nxt  = parity_r ^ a_hot;
      end
      if (cmd.edge_wr) begin
        row_valid_nxt = row_valid_r | (NODES'(1) << src_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r     <= '0;
      parity_r      <= '0;
      row_valid_r   <= '0;
      present_cnt_r <= '0;
    end else begin
      present_r     <= present_nxt;
      parity_r      <= parity_nxt;
      row_valid_r   <= row_valid_nxt;
      present_cnt_r <= present_cnt_nxt;
    end
  end

  // adjacency memory: registered read, row write completes an edge
  always_ff @(posedge clk) begin
    adj_q_r <= adj_mem[adj_addr];
    adj_v_r <= row_valid_r[adj_addr];
    if (cmd.edge_wr) begin
      adj_mem[src_r] <= row_cur | (NODES'(1) << dst_r);
    end
    if (cmd.edge_start) begin
      src_r <= a_idx;
      dst_r <= b_idx;
    end
  end

  // walk stack memory: registered read of the top entry
  always_ff @(posedge clk) begin
    stk_q_r <= stack_mem[sp_r - IDX_W'(1)];
    if (cmd.push) begin
      stack_mem[sp_r] <= low_idx;
    end
  end

  // depth-first walk bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      visited_r <= a_hot;
      reached_r <= CNT_W'(1);
      sp_r      <= '0;
    end else if (cmd.push) begin
      visited_r <= visited_r | low;
      fresh_r   <= fresh_r ^ low;
      reached_r <= reached_r + CNT_W'(1);
      sp_r      <= sp_r + IDX_W'(1);
    end else if (cmd.pop) begin
      sp_r <= sp_r - IDX_W'(1);
    end else if (cmd.load_fresh) begin
      fresh_r <= row_cur & ~visited_r;
    end
  end

  // result register
  assign all_even = ~|parity_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      all_even_r    <= all_even;
      is_eulerian_r <= all_even && (reached_r == present_cnt_r);
      reached_out_r <= COUNT_W'(reached_r);
      present_out_r <= COUNT_W'(present_cnt_r);
    end
  end

  assign out_is_eulerian   = is_eulerian_r;
  assign out_all_even      = all_even_r;
  assign out_reached_count = reached_out_r;
  assign out_present_count = present_out_r;

  assign stat.fresh_empty = (fresh_r == '0);
  assign stat.stack_empty = (sp_r == '0);

  // running present count tracks the present set
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    present_cnt_r == CNT_W'($countones(present_r)))
    else $error("present count out of step with present set");

  // every reached node is marked visited exactly once
  a_reached_matches_visited: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_fresh |-> (reached_r == CNT_W'($countones(visited_r))))
    else $error("reached count out of step with visited set");

  // a pushed node was not visited before
  a_push_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> ((low & visited_r) == '0))
    else $error("node pushed twice");

endmodule

FILE: design/eulerian_graph_check.sv
// Eulerian circuit test over a directed graph of NODES nodes, loaded one request at a time.
// Clear and declare requests finish on acceptance; an edge request reads, then writes
// back, one adjacency row. A query runs a depth-first walk from its start node through
// one adjacency memory read port and a walk stack memory. It accepts the request, then
// loads the start row and pushes each unvisited successor; when none is left it pops a
// node, reads its row and loads it (stack pop, row read, row load). A final empty scan
// and the result load follow; the result load waits while the previous result is unread.
// One query is in work at a time; a finished result sits in an output register, so the
// next request is taken while the previous result waits to be read. Reset and the clear
// request empty the graph at once through per-row valid bits.
`timescale 1ns / 1ps

module eulerian_graph_check #(
  parameter int NODES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  egc_in_if.sink    in_chan,
  egc_out_if.source out_chan
);
  import egc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  egc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_mode   (in_chan.mode),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath
  egc_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_node           (in_chan.node),
    .in_target         (in_chan.target),
    .out_is_eulerian   (out_chan.is_eulerian),
    .out_all_even      (out_chan.all_even),
    .out_reached_count (out_chan.reached_count),
    .out_present_count (out_chan.present_count)
  );

endmodule
